// ===== src/ssh_pkg.sv =====
`default_nettype none

package ssh_pkg;

	// Buffer and FIFO geometry
	localparam int TX_BUF_BYTES  = 256;
	localparam int CFG_BUF_BYTES = 64;
	localparam int TX_FIFO_DEPTH = 8;
	localparam int RESULT_MAX    = 8;
	localparam int HEAD_MAX      = 4;

	localparam int TXB_AW     = $clog2(TX_BUF_BYTES);
	localparam int PAIR_AW    = TXB_AW - 1;
	localparam int PAIR_DEPTH = TX_BUF_BYTES / 2;
	localparam int LEN_W      = 9;
	localparam int HW_W       = 8;
	localparam int CNT_W      = 4;

	// Protocol words
	localparam logic [15:0] CMD_GC      = 16'h8005;
	localparam logic [15:0] CMD_CFG     = 16'h8006;
	localparam logic [15:0] WORD_DUMMY  = 16'hAA55;
	localparam logic [15:0] WORD_FILLER = 16'hC0DE;

	// Request codes
	localparam logic [2:0] REQ_WORD     = 3'd0;
	localparam logic [2:0] REQ_SEL_ON   = 3'd1;
	localparam logic [2:0] REQ_SEL_OFF  = 3'd2;
	localparam logic [2:0] REQ_UNDERRUN = 3'd3;
	localparam logic [2:0] REQ_LOAD     = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_PUSH    = 2'd0;
	localparam logic [1:0] KIND_CAPTURE = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;
	localparam logic [1:0] KIND_FLUSH   = 2'd3;

	// Configuration register indexes
	localparam logic CFG_CAUSE = 1'b0;
	localparam logic CFG_PRIME = 1'b1;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] rx_word;
		logic [3:0]  tx_free;
		logic [8:0]  pending_len;
		logic [7:0]  byte_index;
		logic [7:0]  byte_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] tx_word;
		logic [6:0]  cfg_len;
		logic        last;
	} out_item_t;

	localparam int RES_W = $bits(out_item_t);

	// Work handed from the command decoder to the result sequencer
	typedef struct packed {
		out_item_t [HEAD_MAX-1:0] head;
		logic [2:0]               hcnt;
		logic [CNT_W-1:0]         dcnt;
		logic [CNT_W-1:0]         pcnt;
		logic                     pos_clr;
	} plan_t;

endpackage

`default_nettype wire

// ===== src/ssh_txbuf.sv =====
`default_nettype none

module ssh_txbuf import ssh_pkg::*; (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [TXB_AW-1:0]  wr_idx,
	input  logic [7:0]         wr_byte,
	input  logic [PAIR_AW-1:0] rd_addr,
	output logic [15:0]        rd_data
);

	// Even bytes form the high half of a pair, odd bytes the low half
	logic [7:0] even_mem [PAIR_DEPTH];
	logic [7:0] odd_mem  [PAIR_DEPTH];
	logic [15:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_idx[0]) begin
			even_mem[wr_idx[TXB_AW-1:1]] <= wr_byte;
		end
		if (wr_en && wr_idx[0]) begin
			odd_mem[wr_idx[TXB_AW-1:1]] <= wr_byte;
		end
		rd_q <= {even_mem[rd_addr], odd_mem[rd_addr]};
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== src/ssh_cmd.sv =====
`default_nettype none

module ssh_cmd import ssh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  in_item_t         item,
	input  logic [15:0]      cause_code,
	input  logic [3:0]       prime_count,
	output plan_t            plan,
	output logic [LEN_W-1:0] buf_len
);

	typedef enum logic [5:0] {
		CS_IDLE    = 6'b000001,
		CS_GC_T1   = 6'b000010,
		CS_GC_LEN  = 6'b000100,
		CS_GC_T2   = 6'b001000,
		CS_CFG     = 6'b010000,
		CS_CFG_PKT = 6'b100000
	} cmd_state_t;

	typedef enum logic [2:0] {
		TS_IDLE       = 3'b001,
		TS_WAIT_END   = 3'b010,
		TS_WAIT_START = 3'b100
	} txn_state_t;

	cmd_state_t       cmd_q, cmd_d;
	txn_state_t       txn_q, txn_d;
	logic [LEN_W-1:0] buf_len_q, len_d;
	logic [HW_W-1:0]  hw_q, hw_d;

	logic [3:0]       avail;
	logic [LEN_W-1:0] plen;
	logic [LEN_W-1:0] cfg_len;
	logic [HW_W-1:0]  hw_new;
	logic             flush_go;
	logic [3:0]       prime_sat;
	logic [3:0]       prime_cap;

	// Half-words to send for a byte length, rounded up to a multiple of 4 bytes
	function automatic logic [HW_W-1:0] hw_of(input logic [LEN_W-1:0] len);
		logic [LEN_W:0] t;
		t = {1'b0, len} + (LEN_W+1)'(3);
		return {t[LEN_W-1:2], 1'b0};
	endfunction

	function automatic logic [CNT_W-1:0] min_cnt(input logic [HW_W-1:0] hw,
			input logic [3:0] av);
		return (hw < {4'b0, av}) ? hw[CNT_W-1:0] : av;
	endfunction

	function automatic out_item_t mk(input logic [1:0] kind, input logic [15:0] word,
			input logic [6:0] len);
		out_item_t r;
		r.kind    = kind;
		r.tx_word = word;
		r.cfg_len = len;
		r.last    = 1'b0;
		return r;
	endfunction

	always_comb begin
		plan     = '0;
		cmd_d    = cmd_q;
		txn_d    = txn_q;
		len_d    = buf_len_q;
		hw_d     = hw_q;
		flush_go = 1'b0;

		avail   = (item.tx_free > 4'(TX_FIFO_DEPTH)) ? 4'(TX_FIFO_DEPTH) : item.tx_free;
		plen    = (item.pending_len > LEN_W'(TX_BUF_BYTES)) ? LEN_W'(TX_BUF_BYTES)
			: item.pending_len;
		cfg_len = (item.rx_word > 16'(CFG_BUF_BYTES)) ? LEN_W'(CFG_BUF_BYTES)
			: item.rx_word[LEN_W-1:0];
		hw_new  = hw_of(plen);

		unique case (item.req_type)
			REQ_WORD: begin
				unique case (cmd_q)
					CS_IDLE: begin
						if (item.rx_word == CMD_GC) begin
							cmd_d = CS_GC_T1;
						end else if (item.rx_word == CMD_CFG) begin
							cmd_d = CS_CFG;
						end
					end
					CS_GC_T1: begin
						if (item.rx_word != 16'h0000) begin
							cmd_d = CS_IDLE;
						end else begin
							len_d        = plen;
							hw_d         = hw_new;
							plan.pos_clr = 1'b1;
							plan.head[0] = mk(KIND_PUSH, CMD_GC, 7'd0);
							plan.head[1] = mk(KIND_PUSH, cause_code, 7'd0);
							if (avail < 4'd4) begin
								plan.hcnt = 3'd2;
								cmd_d     = CS_GC_LEN;
							end else begin
								plan.head[2] = mk(KIND_PUSH, 16'h0000, 7'd0);
								plan.head[3] = mk(KIND_PUSH, 16'(plen), 7'd0);
								plan.hcnt    = 3'd4;
								plan.dcnt    = min_cnt(hw_new, avail - 4'd4);
								cmd_d        = CS_GC_T2;
								txn_d        = (plen != '0) ? TS_WAIT_START : TS_WAIT_END;
							end
						end
					end
					CS_GC_LEN: begin
						if (avail >= 4'd2) begin
							plan.head[0] = mk(KIND_PUSH, 16'h0000, 7'd0);
							plan.head[1] = mk(KIND_PUSH, 16'(buf_len_q), 7'd0);
							plan.hcnt    = 3'd2;
							plan.dcnt    = min_cnt(hw_q, avail - 4'd2);
							cmd_d        = CS_GC_T2;
							txn_d        = (buf_len_q != '0) ? TS_WAIT_START : TS_WAIT_END;
						end
					end
					CS_GC_T2: begin
						plan.dcnt = min_cnt(hw_q, avail);
					end
					CS_CFG: begin
						plan.head[0] = mk(KIND_PUSH, WORD_FILLER, 7'd0);
						plan.hcnt    = 3'd1;
						len_d        = cfg_len;
						hw_d         = hw_of(cfg_len);
						cmd_d        = CS_CFG_PKT;
					end
					CS_CFG_PKT: begin
						plan.head[0] = mk(KIND_PUSH, WORD_FILLER, 7'd0);
						if (hw_q != '0) begin
							plan.head[1] = mk(KIND_CAPTURE, item.rx_word, 7'd0);
							plan.hcnt    = 3'd2;
							hw_d         = hw_q - HW_W'(1);
						end else begin
							plan.hcnt = 3'd1;
						end
					end
					default: ;
				endcase
			end
			REQ_SEL_ON: begin
				if (txn_q == TS_WAIT_START) begin
					txn_d = TS_WAIT_END;
				end
			end
			REQ_SEL_OFF: begin
				if (txn_q == TS_WAIT_END || cmd_q == CS_IDLE || cmd_q == CS_CFG_PKT) begin
					flush_go = 1'b1;
				end
			end
			REQ_UNDERRUN: flush_go = 1'b1;
			default: ;
		endcase

		// Flush, optionally preceded by the config-done report, then prime
		if (flush_go) begin
			if (item.req_type == REQ_SEL_OFF && cmd_q == CS_CFG_PKT) begin
				plan.head[0] = mk(KIND_DONE, 16'h0000, buf_len_q[6:0]);
				plan.head[1] = mk(KIND_FLUSH, 16'h0000, 7'd0);
				plan.hcnt    = 3'd2;
			end else begin
				plan.head[0] = mk(KIND_FLUSH, 16'h0000, 7'd0);
				plan.hcnt    = 3'd1;
			end
			cmd_d = CS_IDLE;
			txn_d = TS_IDLE;
		end
		prime_sat = (prime_count > 4'(TX_FIFO_DEPTH)) ? 4'(TX_FIFO_DEPTH) : prime_count;
		prime_cap = 4'(RESULT_MAX) - {1'b0, plan.hcnt};
		if (flush_go) begin
			plan.pcnt = (prime_sat > prime_cap) ? prime_cap : prime_sat;
		end

		hw_d = hw_d - {{(HW_W-CNT_W){1'b0}}, plan.dcnt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= CS_IDLE;
			txn_q     <= TS_IDLE;
			buf_len_q <= '0;
			hw_q      <= '0;
		end else if (start) begin
			cmd_q     <= cmd_d;
			txn_q     <= txn_d;
			buf_len_q <= len_d;
			hw_q      <= hw_d;
		end
	end

	assign buf_len = buf_len_q;

endmodule

`default_nettype wire

// ===== src/ssh_seq.sv =====
`default_nettype none

module ssh_seq import ssh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  plan_t              plan,
	input  logic [LEN_W-1:0]   buf_len,
	input  logic [15:0]        rd_data,
	output logic [PAIR_AW-1:0] rd_addr,
	output logic               idle,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data
);

	typedef enum logic [3:0] {
		SQ_IDLE  = 4'b0001,
		SQ_HEAD  = 4'b0010,
		SQ_DATA  = 4'b0100,
		SQ_PRIME = 4'b1000
	} seq_state_t;

	seq_state_t               st_q, st_d;
	out_item_t [HEAD_MAX-1:0] hd_q;
	logic [2:0]               hcnt_q;
	logic [CNT_W-1:0]         dcnt_q, pcnt_q, rem_q;
	logic [TXB_AW:0]          pos_q, pos_d, pos_nx;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic        adv;
	logic [TXB_AW+1:0] pos_inc;
	logic [TXB_AW+1:0] len_ext;
	logic [15:0] dword;
	out_item_t   emit;

	function automatic seq_state_t pick(input logic h, input logic d, input logic p);
		if (h) begin
			return SQ_HEAD;
		end else if (d) begin
			return SQ_DATA;
		end else if (p) begin
			return SQ_PRIME;
		end
		return SQ_IDLE;
	endfunction

	always_comb begin
		adv = (st_q != SQ_IDLE) && (!out_valid_q || out_ready);

		// Next big-endian pair, a lone high byte at an odd end, or zero padding
		pos_inc = {1'b0, pos_q} + (TXB_AW+2)'(1);
		len_ext = (TXB_AW+2)'(buf_len);
		if (pos_inc < len_ext) begin
			dword  = rd_data;
			pos_nx = pos_q + (TXB_AW+1)'(2);
		end else if (pos_inc == len_ext) begin
			dword  = {rd_data[15:8], 8'h00};
			pos_nx = pos_q + (TXB_AW+1)'(1);
		end else begin
			dword  = 16'h0000;
			pos_nx = pos_q;
		end

		emit = '0;
		unique case (st_q)
			SQ_HEAD:  emit = hd_q[0];
			SQ_DATA: begin
				emit.kind    = KIND_PUSH;
				emit.tx_word = dword;
			end
			SQ_PRIME: begin
				emit.kind    = KIND_PUSH;
				emit.tx_word = WORD_DUMMY;
			end
			default: ;
		endcase
		emit.last = (rem_q == CNT_W'(1));

		st_d = st_q;
		if (start) begin
			st_d = pick(plan.hcnt != '0, plan.dcnt != '0, plan.pcnt != '0);
		end else if (adv) begin
			unique case (st_q)
				SQ_HEAD:  if (hcnt_q == 3'd1) st_d = pick(1'b0, dcnt_q != '0, pcnt_q != '0);
				SQ_DATA:  if (dcnt_q == CNT_W'(1)) st_d = pick(1'b0, 1'b0, pcnt_q != '0);
				SQ_PRIME: if (pcnt_q == CNT_W'(1)) st_d = SQ_IDLE;
				default: ;
			endcase
		end

		// Read ahead at the next pointer so the read data matches the pointer
		if (start && plan.pos_clr) begin
			pos_d = '0;
		end else if (adv && st_q == SQ_DATA) begin
			pos_d = pos_nx;
		end else begin
			pos_d = pos_q;
		end
		rd_addr = pos_d[TXB_AW-1:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= SQ_IDLE;
			hcnt_q      <= '0;
			dcnt_q      <= '0;
			pcnt_q      <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			pos_q <= pos_d;
			if (start) begin
				hcnt_q <= plan.hcnt;
				dcnt_q <= plan.dcnt;
				pcnt_q <= plan.pcnt;
				rem_q  <= CNT_W'(plan.hcnt) + plan.dcnt + plan.pcnt;
			end else if (adv) begin
				rem_q <= rem_q - CNT_W'(1);
				unique case (st_q)
					SQ_HEAD:  hcnt_q <= hcnt_q - 3'd1;
					SQ_DATA:  dcnt_q <= dcnt_q - CNT_W'(1);
					SQ_PRIME: pcnt_q <= pcnt_q - CNT_W'(1);
					default: ;
				endcase
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hd_q <= plan.head;
		end else if (adv && st_q == SQ_HEAD) begin
			hd_q <= hd_q >> RES_W;
		end
		if (adv) begin
			out_q <= emit;
		end
	end

	assign idle      = (st_q == SQ_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== src/spi_slave_host_command_engine_top.sv =====
// Channel   Handshake              Payload      Moves
// in        in_valid / in_ready    in_data      one bus event or store load per item
// out       out_valid / out_ready  out_data     one FIFO push, capture, done or flush
// cfg       cfg_we                 cfg_index,   cause word / prime count, write only
//                                  cfg_wdata
//
// An item is taken when in_ready is high, then its results leave one per cycle
// while out_ready allows: an item with n results (up to 8) holds in_ready low
// until all n have left the sequencer. Items with no result follow back to back.
// Transmit data comes from the byte store one pair per cycle, as out_ready allows.
// Reset clears the command and transaction state, the sequencer and out_valid;
// the byte store and the out_data register are not cleared. A stall on out_ready
// holds the sequencer; the last result of an item may wait while the next is taken.
`default_nettype none

module spi_slave_host_command_engine_top import ssh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [15:0]        cause_q;
	logic [3:0]         prime_q;
	logic               in_fire;
	logic               seq_idle;
	logic               wr_en;
	logic [PAIR_AW-1:0] rd_addr;
	logic [15:0]        rd_data;
	logic [LEN_W-1:0]   buf_len;
	plan_t              plan;

	// Accept a new item only when the sequencer has drained the previous one
	assign in_ready = seq_idle;
	assign in_fire  = in_valid && in_ready;
	assign wr_en    = in_fire && (in_data.req_type == REQ_LOAD);

	// Configuration registers: cause word and number of priming dummies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cause_q <= 16'd8;
			prime_q <= 4'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAUSE: cause_q <= cfg_wdata;
				CFG_PRIME: prime_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Transmit byte store, read as big-endian byte pairs
	ssh_txbuf u_txbuf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (in_data.byte_index),
		.wr_byte (in_data.byte_value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Command decode: update protocol state and plan the item's results
	ssh_cmd u_cmd (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_fire),
		.item        (in_data),
		.cause_code  (cause_q),
		.prime_count (prime_q),
		.plan        (plan),
		.buf_len     (buf_len)
	);

	// Result sequencer: fixed words, store data, then primes, through the
	// output register
	ssh_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_fire),
		.plan      (plan),
		.buf_len   (buf_len),
		.rd_data   (rd_data),
		.rd_addr   (rd_addr),
		.idle      (seq_idle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
